@@ sv/rsi_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and the fixed-point multiply for the ray/sphere test
// no dependencies

package rsi_pkg;

    localparam int FRAC_BITS = 16;

    // square root of a value shifted up by the fraction bits
    localparam int SQ_VW = 31 + FRAC_BITS;
    localparam int SQ_RW = (SQ_VW + 1) / 2;
    // dividend width of the fixed divide
    localparam int DIV_NW = 32 + FRAC_BITS;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 2'd3;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } t_ray;

    typedef struct packed {
        logic               hit;
        logic        [30:0] hit_t;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
    } t_hit;

    // values riding along beside the square root and divide units
    typedef struct packed {
        logic [5:0][31:0] w;
        logic [31:0]      s0;
        logic [31:0]      s1;
        logic             f0;
        logic             f1;
    } t_side;

    // full product, floor shift by the fraction bits, wrap to 32 bits
    function automatic logic [31:0] fmul(input logic signed [31:0] x,
                                         input logic signed [31:0] y);
        logic signed [63:0] p;
        p = x * y;
        return p[FRAC_BITS+31:FRAC_BITS];
    endfunction

endpackage

@@ sv/rsi_ray_if.sv @@
`timescale 1ns / 1ps
// ray input channel: valid, ready and the ray payload
// depends on rsi_pkg

interface rsi_ray_if;
    logic          valid;
    logic          ready;
    rsi_pkg::t_ray data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ sv/rsi_hit_if.sv @@
`timescale 1ns / 1ps
// result channel: valid, ready and the hit payload
// depends on rsi_pkg

interface rsi_hit_if;
    logic          valid;
    logic          ready;
    rsi_pkg::t_hit data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ sv/ray_sphere_intersect.sv @@
`timescale 1ns / 1ps
// datapath: two bit-per-stage square roots (RW = (32+FRAC_BITS)/2 root bits) and two
// bit-per-stage divides (NW = 32+FRAC_BITS dividend bits) in series with the multiply stages
// throughput: one ray per cycle while the result side is ready; any empty stage takes a new ray
// even while the result register is stalled
// reset clears all stage valid bits and loads the sphere registers with their defaults

module ray_sphere_intersect (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rsi_ray_if.sink                         i_ray,
    rsi_hit_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                     i_cfg_data
);
    // sphere registers
    logic [31:0] r_cen [3];
    logic [30:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen[0] <= '0;
            r_cen[1] <= '0;
            r_cen[2] <= '0;
            r_radius <= rsi_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rsi_pkg::CFG_CENTER_X: r_cen[0] <= i_cfg_data;
                rsi_pkg::CFG_CENTER_Y: r_cen[1] <= i_cfg_data;
                rsi_pkg::CFG_CENTER_Z: r_cen[2] <= i_cfg_data;
                rsi_pkg::CFG_RADIUS:   r_radius <= i_cfg_data[30:0];
            endcase
        end
    end

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v7, r_v8, r_v9, r_v10, r_v11, r_vo;
    logic en1, en2, en3, en4, en5, en7, en8, en9, en10, en11, en_out;
    logic sq1_ready, sq1_valid, dv1_ready, dv1_valid;
    logic sq2_ready, sq2_valid, dv2_ready, dv2_valid;

    assign en_out = !r_vo || o_res.ready;
    assign en11   = !r_v11 || sq2_ready;
    assign en10   = !r_v10 || en11;
    assign en9    = !r_v9 || en10;
    assign en8    = !r_v8 || en9;
    assign en7    = !r_v7 || en8;
    assign en5    = !r_v5 || sq1_ready;
    assign en4    = !r_v4 || en5;
    assign en3    = !r_v3 || en4;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign i_ray.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
            r_v7 <= 1'b0; r_v8 <= 1'b0; r_v9 <= 1'b0; r_v10 <= 1'b0; r_v11 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1)    r_v1  <= i_ray.valid;
            if (en2)    r_v2  <= r_v1;
            if (en3)    r_v3  <= r_v2;
            if (en4)    r_v4  <= r_v3;
            if (en5)    r_v5  <= r_v4;
            if (en7)    r_v7  <= dv1_valid;
            if (en8)    r_v8  <= r_v7;
            if (en9)    r_v9  <= r_v8;
            if (en10)   r_v10 <= r_v9;
            if (en11)   r_v11 <= r_v10;
            if (en_out) r_vo  <= dv2_valid;
        end
    end

    // front: e = C - o, products, quadratic terms, discriminant
    logic [31:0] in_o [3];
    logic [31:0] in_d [3];
    assign in_o[0] = i_ray.data.origin_x;
    assign in_o[1] = i_ray.data.origin_y;
    assign in_o[2] = i_ray.data.origin_z;
    assign in_d[0] = i_ray.data.dir_x;
    assign in_d[1] = i_ray.data.dir_y;
    assign in_d[2] = i_ray.data.dir_z;

    logic [31:0] r1_o [3], r1_d [3], r1_e [3];
    logic [31:0] r2_o [3], r2_d [3], r2_dd [3], r2_de [3], r2_ee [3];
    logic [31:0] r2_rr;
    logic [31:0] r3_o [3], r3_d [3];
    logic [31:0] r3_a, r3_b, r3_c;
    logic [31:0] r4_o [3], r4_d [3];
    logic [31:0] r4_a, r4_b, r4_bb, r4_a4c;
    logic [31:0] r5_disc;
    rsi_pkg::t_side r5_side;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int i = 0; i < 3; i++) begin
                r1_o[i] <= in_o[i];
                r1_d[i] <= in_d[i];
                r1_e[i] <= r_cen[i] - in_o[i];
            end
        end
        if (en2) begin
            for (int i = 0; i < 3; i++) begin
                r2_o[i]  <= r1_o[i];
                r2_d[i]  <= r1_d[i];
                r2_dd[i] <= rsi_pkg::fmul(r1_d[i], r1_d[i]);
                r2_de[i] <= rsi_pkg::fmul(r1_d[i], r1_e[i]);
                r2_ee[i] <= rsi_pkg::fmul(r1_e[i], r1_e[i]);
            end
            r2_rr <= rsi_pkg::fmul({1'b0, r_radius}, {1'b0, r_radius});
        end
        if (en3) begin
            for (int i = 0; i < 3; i++) begin
                r3_o[i] <= r2_o[i];
                r3_d[i] <= r2_d[i];
            end
            r3_a <= r2_dd[0] + r2_dd[1] + r2_dd[2];
            // times minus two
            r3_b <= 32'd0 - {r2_de[0][30:0] + r2_de[1][30:0] + r2_de[2][30:0], 1'b0};
            r3_c <= r2_ee[0] + r2_ee[1] + r2_ee[2] - r2_rr;
        end
        if (en4) begin
            for (int i = 0; i < 3; i++) begin
                r4_o[i] <= r3_o[i];
                r4_d[i] <= r3_d[i];
            end
            r4_a   <= r3_a;
            r4_b   <= r3_b;
            r4_bb  <= rsi_pkg::fmul(r3_b, r3_b);
            r4_a4c <= rsi_pkg::fmul({r3_a[29:0], 2'b00}, r3_c);
        end
        if (en5) begin
            r5_disc <= r4_bb - r4_a4c;
            for (int i = 0; i < 3; i++) begin
                r5_side.w[i]     <= r4_o[i];
                r5_side.w[3 + i] <= r4_d[i];
            end
            r5_side.s0 <= r4_b;
            r5_side.s1 <= {r4_a[30:0], 1'b0};
            // no hit on negative discriminant, zero a, or doubled a wrapping to zero
            r5_side.f0 <= (r4_bb - r4_a4c) >= 32'h8000_0000 || r4_a == '0
                       || r4_a[30:0] == '0;
            r5_side.f1 <= 1'b0;
        end
    end

    logic [31:0]      sq1_root;
    rsi_pkg::t_side   sq1_side;

    rsi_sqrt u_sqrt_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v5),
        .o_ready (sq1_ready),
        .i_x     (r5_disc),
        .i_side  (r5_side),
        .o_valid (sq1_valid),
        .i_ready (dv1_ready),
        .o_root  (sq1_root),
        .o_side  (sq1_side)
    );

    // roots (-b + sqrt) / 2a and (-b - sqrt) / 2a
    logic [2:0][31:0] dv1_num;
    logic [2:0][31:0] dv1_q;
    rsi_pkg::t_side   dv1_side;
    assign dv1_num[0] = sq1_root - sq1_side.s0;
    assign dv1_num[1] = 32'd0 - sq1_side.s0 - sq1_root;
    assign dv1_num[2] = '0;

    rsi_div u_div_roots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq1_valid),
        .o_ready (dv1_ready),
        .i_num   (dv1_num),
        .i_den   (sq1_side.s1),
        .i_side  (sq1_side),
        .o_valid (dv1_valid),
        .i_ready (en7),
        .o_q     (dv1_q),
        .o_side  (dv1_side)
    );

    // back: pick t, hit point, vector from the center, its length
    logic [31:0] r7_o [3], r7_d [3];
    logic [31:0] r7_t;
    logic        r7_hit;
    logic [31:0] r8_o [3], r8_m [3];
    logic [31:0] r8_t;
    logic        r8_hit;
    logic [31:0] r9_p [3], r9_v [3];
    logic [31:0] r9_t;
    logic        r9_hit;
    logic [31:0] r10_p [3], r10_v [3], r10_vv [3];
    logic [31:0] r10_t;
    logic        r10_hit;
    logic [31:0] r11_len2;
    rsi_pkg::t_side r11_side;

    logic        ok1, ok2;
    logic [31:0] t_sel;
    always_comb begin
        ok1 = !dv1_q[0][31];
        ok2 = !dv1_q[1][31];
        if (ok1 && ok2) begin
            t_sel = ($signed(dv1_q[0]) < $signed(dv1_q[1])) ? dv1_q[0] : dv1_q[1];
        end else begin
            t_sel = ok1 ? dv1_q[0] : dv1_q[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en7) begin
            for (int i = 0; i < 3; i++) begin
                r7_o[i] <= dv1_side.w[i];
                r7_d[i] <= dv1_side.w[3 + i];
            end
            r7_t   <= t_sel;
            r7_hit <= !dv1_side.f0 && (ok1 || ok2);
        end
        if (en8) begin
            for (int i = 0; i < 3; i++) begin
                r8_o[i] <= r7_o[i];
                r8_m[i] <= rsi_pkg::fmul(r7_d[i], r7_t);
            end
            r8_t   <= r7_t;
            r8_hit <= r7_hit;
        end
        if (en9) begin
            for (int i = 0; i < 3; i++) begin
                r9_p[i] <= r8_o[i] + r8_m[i];
                r9_v[i] <= r8_o[i] + r8_m[i] - r_cen[i];
            end
            r9_t   <= r8_t;
            r9_hit <= r8_hit;
        end
        if (en10) begin
            for (int i = 0; i < 3; i++) begin
                r10_p[i]  <= r9_p[i];
                r10_v[i]  <= r9_v[i];
                r10_vv[i] <= rsi_pkg::fmul(r9_v[i], r9_v[i]);
            end
            r10_t   <= r9_t;
            r10_hit <= r9_hit;
        end
        if (en11) begin
            r11_len2 <= r10_vv[0] + r10_vv[1] + r10_vv[2];
            for (int i = 0; i < 3; i++) begin
                r11_side.w[i]     <= r10_p[i];
                r11_side.w[3 + i] <= r10_v[i];
            end
            r11_side.s0 <= r10_t;
            r11_side.s1 <= '0;
            r11_side.f0 <= r10_hit;
            r11_side.f1 <= 1'b0;
        end
    end

    logic [31:0]      sq2_root;
    rsi_pkg::t_side   sq2_side;
    rsi_pkg::t_side   dv2_in_side;
    logic [2:0][31:0] dv2_num;
    logic [2:0][31:0] dv2_q;
    rsi_pkg::t_side   dv2_side;

    rsi_sqrt u_sqrt_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v11),
        .o_ready (sq2_ready),
        .i_x     (r11_len2),
        .i_side  (r11_side),
        .o_valid (sq2_valid),
        .i_ready (dv2_ready),
        .o_root  (sq2_root),
        .o_side  (sq2_side)
    );

    always_comb begin
        dv2_in_side    = sq2_side;
        // degenerate normal when the length is zero
        dv2_in_side.f1 = sq2_root != '0;
        for (int i = 0; i < 3; i++) dv2_num[i] = sq2_side.w[3 + i];
    end

    rsi_div u_div_normal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq2_valid),
        .o_ready (dv2_ready),
        .i_num   (dv2_num),
        .i_den   (sq2_root),
        .i_side  (dv2_in_side),
        .o_valid (dv2_valid),
        .i_ready (en_out),
        .o_q     (dv2_q),
        .o_side  (dv2_side)
    );

    rsi_pkg::t_hit r_out;
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            if (dv2_side.f0) begin
                r_out.hit      <= 1'b1;
                r_out.hit_t    <= dv2_side.s0[30:0];
                r_out.point_x  <= dv2_side.w[0];
                r_out.point_y  <= dv2_side.w[1];
                r_out.point_z  <= dv2_side.w[2];
                r_out.normal_x <= dv2_side.f1 ? dv2_q[0] : '0;
                r_out.normal_y <= dv2_side.f1 ? dv2_q[1] : '0;
                r_out.normal_z <= dv2_side.f1 ? dv2_q[2] : '0;
            end else begin
                r_out <= '0;
            end
        end
    end

    assign o_res.valid = r_vo;
    assign o_res.data  = r_out;

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.data.hit |->
            o_res.data.hit_t == '0 && o_res.data.point_x == '0
            && o_res.data.point_y == '0 && o_res.data.point_z == '0)
        else $error("miss transaction carries nonzero fields");

    a_normal_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (o_res.data.normal_x != '0 || o_res.data.normal_y != '0
            || o_res.data.normal_z != '0) |-> o_res.data.hit)
        else $error("normal present without a hit");

    a_front_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_ray.ready)
        else $error("empty first stage refuses a transaction");

endmodule

@@ sv/rsi_sqrt.sv @@
`timescale 1ns / 1ps
// pipelined fixed-point square root, one root bit per stage, with sideband
// depends on rsi_pkg

module rsi_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [31:0]    i_x,
    input  rsi_pkg::t_side i_side,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_root,
    output rsi_pkg::t_side o_side
);
    localparam int VW = rsi_pkg::SQ_VW;
    localparam int RW = rsi_pkg::SQ_RW;
    localparam int NS = RW + 1;

    logic           r_v    [NS];
    logic [VW-1:0]  r_rem  [NS];
    logic [RW-1:0]  r_root [NS];
    rsi_pkg::t_side r_side [NS];

    logic           en     [NS+1];
    logic [VW-1:0]  n_rem  [NS];
    logic [RW-1:0]  n_root [NS];

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign o_ready = en[0];

    always_comb begin
        logic [VW+1:0] test;
        logic [VW+1:0] cur;
        int            i;
        // zero or negative input gives a zero root
        n_rem[0]  = ($signed(i_x) > 0) ? {i_x[30:0], {rsi_pkg::FRAC_BITS{1'b0}}} : '0;
        n_root[0] = '0;
        for (int k = 1; k < NS; k++) begin
            i    = RW - k;
            test = ({{(VW + 2 - RW){1'b0}}, r_root[k-1]} << (i + 1))
                 + ((VW + 2)'(1) << (2 * i));
            cur  = {2'b00, r_rem[k-1]};
            if (cur >= test) begin
                n_rem[k]  = VW'(cur - test);
                n_root[k] = r_root[k-1] | (RW'(1) << i);
            end else begin
                n_rem[k]  = r_rem[k-1];
                n_root[k] = r_root[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0]  <= n_rem[0];
            r_root[0] <= n_root[0];
            r_side[0] <= i_side;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_root  = {{(32 - RW){1'b0}}, r_root[NS-1]};
    assign o_side  = r_side[NS-1];

endmodule

@@ sv/rsi_div.sv @@
`timescale 1ns / 1ps
// pipelined fixed-point divide, three numerators over one divisor,
// one quotient bit per stage, with sideband; depends on rsi_pkg

module rsi_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [2:0][31:0] i_num,
    input  logic [31:0]      i_den,
    input  rsi_pkg::t_side   i_side,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0][31:0] o_q,
    output rsi_pkg::t_side   o_side
);
    localparam int NW = rsi_pkg::DIV_NW;
    localparam int NS = NW + 1;

    logic           r_v    [NS];
    logic [31:0]    r_d    [NS];
    logic [31:0]    r_rem  [NS][3];
    logic [NW-1:0]  r_a    [NS][3];
    logic           r_sgn  [NS][3];
    rsi_pkg::t_side r_side [NS];

    logic           en     [NS+1];
    logic [31:0]    n_rem  [NS][3];
    logic [NW-1:0]  n_a    [NS][3];
    logic [31:0]    n_d0;
    logic           n_sgn0 [3];

    always_comb begin
        en[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end
    assign o_ready = en[0];

    always_comb begin
        logic [31:0] mag;
        logic [32:0] t;
        logic        ge;
        // magnitudes; quotient sign fixed at the end, truncating toward zero
        n_d0 = i_den[31] ? (32'd0 - i_den) : i_den;
        for (int l = 0; l < 3; l++) begin
            mag          = i_num[l][31] ? (32'd0 - i_num[l]) : i_num[l];
            n_a[0][l]    = {mag, {rsi_pkg::FRAC_BITS{1'b0}}};
            n_rem[0][l]  = '0;
            n_sgn0[l]    = i_num[l][31] ^ i_den[31];
        end
        for (int k = 1; k < NS; k++) begin
            for (int l = 0; l < 3; l++) begin
                t  = {r_rem[k-1][l], r_a[k-1][l][NW-1]};
                ge = t >= {1'b0, r_d[k-1]};
                n_rem[k][l] = ge ? 32'(t - {1'b0, r_d[k-1]}) : t[31:0];
                n_a[k][l]   = {r_a[k-1][l][NW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_d[0]    <= n_d0;
            r_side[0] <= i_side;
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= n_rem[0][l];
                r_a[0][l]   <= n_a[0][l];
                r_sgn[0][l] <= n_sgn0[l];
            end
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_d[k]    <= r_d[k-1];
                r_side[k] <= r_side[k-1];
                for (int l = 0; l < 3; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_a[k][l]   <= n_a[k][l];
                    r_sgn[k][l] <= r_sgn[k-1][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_q[l] = r_sgn[NS-1][l] ? (32'd0 - r_a[NS-1][l][31:0]) : r_a[NS-1][l][31:0];
        end
    end
    assign o_valid = r_v[NS-1];
    assign o_side  = r_side[NS-1];

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// self-checking bench for ray_sphere_intersect: directed table, extreme spheres, then random rays
// depends on rsi_pkg, rsi_ray_if, rsi_hit_if and the block itself

module testbench;

    localparam int LATENCY   = 159;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1500;

    typedef struct {
        rsi_pkg::t_ray ray;
        bit            has_exp;
        rsi_pkg::t_hit exp;
    } t_row;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [rsi_pkg::CFG_IDX_W-1:0] i_cfg_idx = rsi_pkg::CFG_CENTER_X;
    logic [31:0] i_cfg_data = '0;

    rsi_ray_if ray_ch();
    rsi_hit_if hit_ch();

    ray_sphere_intersect i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ray(ray_ch.sink), .o_res(hit_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // sphere as the bench believes the block holds it
    logic signed [31:0] sph_cx = 0, sph_cy = 0, sph_cz = 0;
    logic signed [31:0] sph_r = 32'(rsi_pkg::RADIUS_RESET);

    rsi_pkg::t_hit hit_queue[$];
    int   n_err = 0, n_hits = 0, n_rays = 0, n_miss = 0;
    int   idle_cycles = 0;

    // floor-shifted fixed multiply, 32-bit wrap
    function automatic logic signed [31:0] fx_mul(logic signed [31:0] x,
                                                  logic signed [31:0] y);
        logic signed [63:0] p;
        p = 64'(x) * 64'(y);
        p = p >>> rsi_pkg::FRAC_BITS;
        return p[31:0];
    endfunction

    function automatic logic signed [31:0] fx_div(logic signed [31:0] n,
                                                  logic signed [31:0] d);
        logic signed [63:0] q;
        q = (64'(n) <<< rsi_pkg::FRAC_BITS) / 64'(d);
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] fx_sqrt(logic signed [31:0] x);
        logic [63:0] v, res, bitv;
        if (x <= 0) return 0;
        v = 64'(x) << rsi_pkg::FRAC_BITS;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic logic signed [31:0] fx_dot(logic signed [31:0] ux,
            logic signed [31:0] uy, logic signed [31:0] uz, logic signed [31:0] vx,
            logic signed [31:0] vy, logic signed [31:0] vz);
        return fx_mul(ux, vx) + fx_mul(uy, vy) + fx_mul(uz, vz);
    endfunction

    function automatic rsi_pkg::t_hit trace_ray(rsi_pkg::t_ray r);
        logic signed [31:0] ex, ey, ez, a, b, c, disc, den, root, nb, t1, t2, t;
        logic signed [31:0] px, py, pz, vx, vy, vz, len2, mag;
        rsi_pkg::t_hit h;
        h = '0;
        ex = sph_cx - r.origin_x;
        ey = sph_cy - r.origin_y;
        ez = sph_cz - r.origin_z;
        a = fx_dot(r.dir_x, r.dir_y, r.dir_z, r.dir_x, r.dir_y, r.dir_z);
        b = fx_dot(r.dir_x, r.dir_y, r.dir_z, ex, ey, ez) * -2;
        c = fx_dot(ex, ey, ez, ex, ey, ez) - fx_mul(sph_r, sph_r);
        disc = fx_mul(b, b) - fx_mul(a * 4, c);
        if (disc < 0 || a == 0) return h;
        den = a * 2;
        if (den == 0) return h;
        root = fx_sqrt(disc);
        nb = -b;
        t1 = fx_div(nb + root, den);
        t2 = fx_div(nb - root, den);
        if (t1 < 0 && t2 < 0) return h;
        if (t1 >= 0 && t2 >= 0) t = (t1 < t2) ? t1 : t2;
        else t = (t1 >= 0) ? t1 : t2;
        px = r.origin_x + fx_mul(r.dir_x, t);
        py = r.origin_y + fx_mul(r.dir_y, t);
        pz = r.origin_z + fx_mul(r.dir_z, t);
        vx = px - sph_cx;
        vy = py - sph_cy;
        vz = pz - sph_cz;
        len2 = fx_dot(vx, vy, vz, vx, vy, vz);
        mag = fx_sqrt(len2);
        h.hit = 1;
        h.hit_t = t[30:0];
        h.point_x = px;
        h.point_y = py;
        h.point_z = pz;
        if (mag != 0) begin
            h.normal_x = fx_div(vx, mag);
            h.normal_y = fx_div(vy, mag);
            h.normal_z = fx_div(vz, mag);
        end
        return h;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [31:0] fx(int v);
        return 32'(v) <<< rsi_pkg::FRAC_BITS;
    endfunction

    // random value with occasional full-range or extreme content
    function automatic logic signed [31:0] rnd_coord(int span);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return $urandom;
        if (k == 1) return 32'sh8000_0000;
        if (k == 2) return 32'sh7fff_ffff;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // result side: sample at rising edge, drive ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && hit_ch.valid && hit_ch.ready) begin
            if (hit_queue.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result transaction: %p", hit_ch.data);
            end else begin
                rsi_pkg::t_hit e;
                e = hit_queue.pop_front();
                if (e.hit) n_hits++;
                if (hit_ch.data !== e) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("mismatch at %0t", $realtime);
                        $display("  exp hit=%0d t=%h p=%h %h %h n=%h %h %h", e.hit, e.hit_t,
                                 e.point_x, e.point_y, e.point_z,
                                 e.normal_x, e.normal_y, e.normal_z);
                        $display("  got hit=%0d t=%h p=%h %h %h n=%h %h %h", hit_ch.data.hit,
                                 hit_ch.data.hit_t, hit_ch.data.point_x, hit_ch.data.point_y,
                                 hit_ch.data.point_z, hit_ch.data.normal_x,
                                 hit_ch.data.normal_y, hit_ch.data.normal_z);
                    end
                end
            end
        end
    end

    initial begin : ready_gen
        int g;
        hit_ch.ready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hit_ch.ready <= 1;
            g = $urandom_range(0, 3) == 0 ? 0 : 1;
            if (g == 0) begin
                g = gap_len();
                repeat (g) begin
                    @(negedge i_clk);
                    hit_ch.ready <= 0;
                end
            end else begin
                repeat ($urandom_range(1, 20)) @(negedge i_clk);
            end
        end
    end

    // watchdog on acceptance in either direction
    always @(posedge i_clk) begin
        if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("watchdog expired, %0d results outstanding", hit_queue.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_ray(rsi_pkg::t_ray r, bit has_exp, rsi_pkg::t_hit exp);
        rsi_pkg::t_hit p;
        int g;
        p = trace_ray(r);
        if (has_exp && p !== exp) begin
            n_err++;
            if (n_err <= 10) $display("table entry disagrees with predictor: %p", r);
        end
        g = gap_len();
        if (g != 0) begin
            ray_ch.valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        ray_ch.data <= r;
        ray_ch.valid <= 1;
        @(posedge i_clk);
        while (!ray_ch.ready) @(posedge i_clk);
        hit_queue = {hit_queue, (has_exp ? exp : p)};
        n_rays++;
        if (!p.hit) n_miss++;
        @(negedge i_clk);
    endtask

    // stop sending and wait for every expected result
    task automatic wait_empty();
        ray_ch.valid <= 0;
        while (hit_queue.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        wait_empty();
        repeat (LATENCY + 10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [rsi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        unique case (idx)
            rsi_pkg::CFG_CENTER_X: sph_cx = val;
            rsi_pkg::CFG_CENTER_Y: sph_cy = val;
            rsi_pkg::CFG_CENTER_Z: sph_cz = val;
            rsi_pkg::CFG_RADIUS:   sph_r = {1'b0, val[30:0]};
        endcase
    endtask

    task automatic load_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [31:0] r);
        write_reg(rsi_pkg::CFG_CENTER_X, cx);
        write_reg(rsi_pkg::CFG_CENTER_Y, cy);
        write_reg(rsi_pkg::CFG_CENTER_Z, cz);
        write_reg(rsi_pkg::CFG_RADIUS, r);
    endtask

    t_row dir_table[$];

    function automatic t_row mk(int ox, int oy, int oz, int dx, int dy, int dz);
        t_row w;
        w.ray = '{fx(ox), fx(oy), fx(oz), fx(dx), fx(dy), fx(dz)};
        w.has_exp = 0;
        w.exp = '0;
        return w;
    endfunction

    initial begin : stim
        t_row w;
        rsi_pkg::t_ray r;
        rsi_pkg::t_hit none;
        int span;
        ray_ch.valid = 0;
        ray_ch.data = '0;
        none = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // unit sphere at origin after reset
        w = mk(0, 0, -5, 0, 0, 1);
        w.has_exp = 1;
        w.exp = '{1'b1, 31'(fx(4)), '0, '0, fx(-1), '0, '0, fx(-1)};
        dir_table = {dir_table, w};
        w = mk(0, 0, -5, 0, 0, 0);  w.has_exp = 1; w.exp = none; dir_table = {dir_table, w};
        w = mk(0, 0, -5, 0, 0, -1); w.has_exp = 1; w.exp = none; dir_table = {dir_table, w};
        w = mk(0, 5, -5, 0, 0, 1);  w.has_exp = 1; w.exp = none; dir_table = {dir_table, w};
        dir_table = {dir_table, mk(0, 0, 0, 0, 0, 1)};   // origin inside: one root negative
        dir_table = {dir_table, mk(0, 1, -5, 0, 0, 1)};  // tangent
        dir_table = {dir_table, mk(0, 0, -5, 0, 0, 2)};
        dir_table = {dir_table, mk(-3, 0, 0, 1, 0, 0)};
        dir_table = {dir_table, mk(0, -3, 0, 0, 1, 0)};
        dir_table = {dir_table, mk(0, 0, -1, 0, 0, 1)};  // starts on the surface
        w.has_exp = 0;
        w.ray = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                  32'sh80000000, 32'sh7fffffff, 32'sh80000000};
        dir_table = {dir_table, w};
        w.ray = '{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h1, 32'h1, 32'h1};
        dir_table = {dir_table, w};
        w.ray = '{0, 0, 0, 32'h00800000, 32'h00800000, 0};  // 2a wraps to zero
        dir_table = {dir_table, w};
        w.ray = '{32'hffffffff, 32'hffffffff, 32'hffffffff,
                  32'hffffffff, 32'hffffffff, 32'hffffffff};
        dir_table = {dir_table, w};
        foreach (dir_table[i]) send_ray(dir_table[i].ray, dir_table[i].has_exp,
                                         dir_table[i].exp);
        drain();

        // extreme sphere settings
        load_sphere(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff);
        for (int i = 0; i < 4; i++) begin
            r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            send_ray(r, 0, none);
        end
        drain();
        load_sphere(0, 0, 0, 0);
        send_ray(mk(0, 0, -5, 0, 0, 1).ray, 0, none);
        send_ray(mk(0, 0, 0, 0, 0, 1).ray, 0, none);
        drain();

        // random phases, mostly aimed rays with small magnitudes
        for (int ph = 0; ph < 6; ph++) begin
            span = (ph % 2) ? 40 : 8;
            load_sphere(fx($signed($urandom_range(0, 2 * span)) - span),
                        fx($signed($urandom_range(0, 2 * span)) - span),
                        fx($signed($urandom_range(0, 2 * span)) - span),
                        ph == 5 ? $urandom : 32'($urandom_range(1 << 14, 6 << 16)));
            for (int i = 0; i < N_RANDOM / 6; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    r.origin_x = fx($signed($urandom_range(0, 4 * span)) - 2 * span)
                                 + $signed($urandom_range(0, 65535));
                    r.origin_y = fx($signed($urandom_range(0, 4 * span)) - 2 * span)
                                 + $signed($urandom_range(0, 65535));
                    r.origin_z = fx($signed($urandom_range(0, 4 * span)) - 2 * span);
                    r.dir_x = (sph_cx - r.origin_x) / 8
                              + $signed($urandom_range(0, 8191)) - 4096;
                    r.dir_y = (sph_cy - r.origin_y) / 8
                              + $signed($urandom_range(0, 8191)) - 4096;
                    r.dir_z = (sph_cz - r.origin_z) / 8
                              + $signed($urandom_range(0, 8191)) - 4096;
                end else begin
                    r = '{rnd_coord(1 << 22), rnd_coord(1 << 22), rnd_coord(1 << 22),
                          rnd_coord(1 << 18), rnd_coord(1 << 18), rnd_coord(1 << 18)};
                end
                send_ray(r, 0, none);
                if (i == 100) wait_empty();
            end
            drain();
        end

        $display("sent %0d rays (%0d predicted misses), %0d hits checked across 9 sphere setups",
                 n_rays, n_miss, n_hits);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", n_err);
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ files.f @@
sv/rsi_pkg.sv
sv/rsi_ray_if.sv
sv/rsi_hit_if.sv
sv/rsi_sqrt.sv
sv/rsi_div.sv
sv/ray_sphere_intersect.sv
verif/testbench.sv
